@@ rtl/core/nearest_probe_select_defines.svh @@
// Assertion macros for the nearest probe selector.
// Expects clk_i and rst_ni in the scope where the macros are used.
`ifndef NEAREST_PROBE_SELECT_DEFINES_SVH
`define NEAREST_PROBE_SELECT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define NPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define NPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/nps_pkg.sv @@
// Shared constants, types and helpers for the nearest probe selector.
// No dependencies.
package nps_pkg;

  localparam int unsigned MAX_PROBES = 16;
  localparam int unsigned COORD_BITS = 24;

  localparam int unsigned IDX_W  = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_PROBES + 1);
  // scan counter runs through the ring and then lets the distance pipeline drain
  localparam int unsigned LAST_SCAN = MAX_PROBES + 1;
  localparam int unsigned SCAN_W = $clog2(LAST_SCAN + 1);

  localparam int unsigned SQ_W  = 2 * COORD_BITS;
  localparam int unsigned SUM_W = SQ_W + 2;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned SRC_W  = 2;
  localparam int unsigned OIDX_W = 4;
  localparam int unsigned MODE_W = 2;

  localparam int unsigned IN_DATA_W   = ((3 * COORD_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_FIELD_W = 2 * (SRC_W + OIDX_W);
  localparam int unsigned OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_LIGHT = 2'd0,
    CMD_ADD_REFL  = 2'd1,
    CMD_QUERY     = 2'd2
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_ADDED    = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_ANSWERED = 2'd2
  } stat_e;

  typedef enum logic [SRC_W-1:0] {
    SRC_NEAREST  = 2'd0,
    SRC_FALLBACK = 2'd1,
    SRC_NONE     = 2'd2
  } src_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_NEAREST  = 2'd0,
    MODE_DISABLED = 2'd1,
    MODE_OTHER    = 2'd2
  } mode_e;

  // x in the low bits, matching the stream packing
  typedef struct packed {
    logic [COORD_BITS-1:0] z;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] x;
  } pos_t;

  typedef struct packed {
    logic             load;
    logic [IDX_W-1:0] load_idx;
    logic             shift;
    logic             scan_valid;
    logic [IDX_W-1:0] scan_idx;
  } tbl_ctl_t;

  // low four bits of a table index, zero extended when the index is narrower
  function automatic logic [OIDX_W-1:0] out_idx(input logic [IDX_W-1:0] idx);
    logic [IDX_W+OIDX_W-1:0] w;
    w = {{OIDX_W{1'b0}}, idx};
    return w[OIDX_W-1:0];
  endfunction

endpackage

@@ rtl/core/nearest_probe_select.sv @@
// Nearest light / reflection probe selector, top level.
// Depends on nps_pkg, nps_table and nearest_probe_select_defines.svh.
//
// Input stream: tuser carries the command, tdata the position (x, y, z).
// Each command except the unused code 3 yields one result item on the output
// stream: tuser carries the status, tdata the two sources and indices.
// Config channel writes blend_mode; it is always ready.
//
// Adds store the position in the next free cell of the table in the accept
// cycle; their result passes through the result state into the output
// register. A query in nearest mode with a non-empty table rotates both
// 16-cell rings once, each past its own three-stage distance pipeline, and
// lets the pipelines drain before the result state. Other queries answer
// like adds. One item is in work at a time: a new command is taken only
// once the last one has left the result state.
//
// A finished result waits in a pending stage while the output register is
// held by a stalled receiver; the next item is taken as soon as the block is
// idle. Reset empties both tables and sets blend_mode to nearest.
`include "nearest_probe_select_defines.svh"

module nearest_probe_select (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [nps_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // pos_x, pos_y, pos_z
  input  logic [nps_pkg::CMD_W-1:0]      s_axis_tuser,  // command
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // light_source, light_index, refl_source, refl_index, zero pad
  output logic [nps_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic [nps_pkg::STAT_W-1:0]     m_axis_tuser,  // status
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [nps_pkg::MODE_W-1:0]     cfg_data_i     // blend_mode
);
  import nps_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_RESULT = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [MODE_W-1:0] mode_q;
  logic [CNT_W-1:0]  lcnt_q, lcnt_d, rcnt_q, rcnt_d;
  logic [SCAN_W-1:0] scan_q, scan_d;
  pos_t              qpos_q, qpos_d;
  pos_t              in_pos;
  stat_e             stat_q, stat_d;
  src_e              lsrc_q, lsrc_d, rsrc_q, rsrc_d;
  logic              mval_q, mval_d;
  logic [OUT_DATA_W-1:0] mdata_q, mdata_d;
  logic [STAT_W-1:0] muser_q, muser_d;
  tbl_ctl_t          lctl, rctl;
  logic [IDX_W-1:0]  lbest, rbest;
  logic [OIDX_W-1:0] lidx, ridx;
  logic              accept;
  logic              scan_shift;

  assign in_pos        = pos_t'(s_axis_tdata[3*COORD_BITS-1:0]);
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign scan_shift    = (state_q == S_SCAN) && (scan_q < SCAN_W'(MAX_PROBES));

  assign lidx = (lsrc_q == SRC_NEAREST) ? out_idx(lbest) : '0;
  assign ridx = (rsrc_q == SRC_NEAREST) ? out_idx(rbest) : '0;

  always_comb begin
    state_d = state_q;
    lcnt_d  = lcnt_q;
    rcnt_d  = rcnt_q;
    scan_d  = scan_q;
    qpos_d  = qpos_q;
    stat_d  = stat_q;
    lsrc_d  = lsrc_q;
    rsrc_d  = rsrc_q;
    mdata_d = mdata_q;
    muser_d = muser_q;
    mval_d  = mval_q && !m_axis_tready;
    lctl    = '0;
    rctl    = '0;
    lctl.load_idx = lcnt_q[IDX_W-1:0];
    rctl.load_idx = rcnt_q[IDX_W-1:0];
    lctl.shift    = scan_shift;
    rctl.shift    = scan_shift;
    lctl.scan_valid = scan_shift && (scan_q < SCAN_W'(lcnt_q));
    rctl.scan_valid = scan_shift && (scan_q < SCAN_W'(rcnt_q));
    lctl.scan_idx   = scan_q[IDX_W-1:0];
    rctl.scan_idx   = scan_q[IDX_W-1:0];

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          lsrc_d = SRC_NONE;
          rsrc_d = SRC_NONE;
          case (s_axis_tuser)
            CMD_ADD_LIGHT: begin
              state_d = S_RESULT;
              if (lcnt_q < CNT_W'(MAX_PROBES)) begin
                stat_d    = STAT_ADDED;
                lctl.load = 1'b1;
                lcnt_d    = lcnt_q + 1'b1;
              end else begin
                stat_d = STAT_FULL;
              end
            end
            CMD_ADD_REFL: begin
              state_d = S_RESULT;
              if (rcnt_q < CNT_W'(MAX_PROBES)) begin
                stat_d    = STAT_ADDED;
                rctl.load = 1'b1;
                rcnt_d    = rcnt_q + 1'b1;
              end else begin
                stat_d = STAT_FULL;
              end
            end
            CMD_QUERY: begin
              stat_d  = STAT_ANSWERED;
              qpos_d  = in_pos;
              state_d = S_RESULT;
              case (mode_q)
                MODE_NEAREST: begin
                  lsrc_d = (lcnt_q != '0) ? SRC_NEAREST : SRC_FALLBACK;
                  rsrc_d = (rcnt_q != '0) ? SRC_NEAREST : SRC_FALLBACK;
                  if ((lcnt_q != '0) || (rcnt_q != '0)) begin
                    state_d = S_SCAN;
                    scan_d  = '0;
                  end
                end
                MODE_DISABLED: begin
                  lsrc_d = SRC_FALLBACK;
                  rsrc_d = SRC_FALLBACK;
                end
                default: begin
                  lsrc_d = SRC_NONE;
                  rsrc_d = SRC_NONE;
                end
              endcase
            end
            default: begin
              // unused command: item dropped without a result
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_SCAN: begin
        scan_d = scan_q + 1'b1;
        if (scan_q == SCAN_W'(LAST_SCAN)) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!mval_q || m_axis_tready) begin
          mval_d  = 1'b1;
          mdata_d = OUT_DATA_W'({ridx, rsrc_q, lidx, lsrc_q});
          muser_d = stat_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= '0;
      lcnt_q  <= '0;
      rcnt_q  <= '0;
      scan_q  <= '0;
      mval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      lcnt_q  <= lcnt_d;
      rcnt_q  <= rcnt_d;
      scan_q  <= scan_d;
      mval_q  <= mval_d;
      if (cfg_valid_i) begin
        mode_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    qpos_q  <= qpos_d;
    stat_q  <= stat_d;
    lsrc_q  <= lsrc_d;
    rsrc_q  <= rsrc_d;
    mdata_q <= mdata_d;
    muser_q <= muser_d;
  end

  nps_table u_light (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (lctl),
    .load_pos_i(in_pos),
    .query_i   (qpos_q),
    .best_idx_o(lbest)
  );

  nps_table u_refl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (rctl),
    .load_pos_i(in_pos),
    .query_i   (qpos_q),
    .best_idx_o(rbest)
  );

  assign m_axis_tvalid = mval_q;
  assign m_axis_tdata  = mdata_q;
  assign m_axis_tuser  = muser_q;

  `NPS_ASSERT_IMP(a_cnt_bound, 1'b1, (lcnt_q <= CNT_W'(MAX_PROBES)) && (rcnt_q <= CNT_W'(MAX_PROBES)), "probe count above table size")
  `NPS_ASSERT_NEXT(a_light_add, accept && (s_axis_tuser == CMD_ADD_LIGHT) && (lcnt_q < CNT_W'(MAX_PROBES)), lcnt_q == $past(lcnt_q) + 1'b1, "light add did not grow the table")
  `NPS_ASSERT_NEXT(a_query_scan, accept && (s_axis_tuser == CMD_QUERY) && (mode_q == MODE_NEAREST) && (lcnt_q != '0), (state_q == S_SCAN) && (scan_q == '0), "nearest query did not start a scan")
  `NPS_ASSERT_NEXT(a_scan_end, (state_q == S_SCAN) && (scan_q == SCAN_W'(LAST_SCAN)), state_q == S_RESULT, "scan did not end in result")

endmodule

@@ rtl/core/nps_cell.sv @@
// One probe slot of the ring: loads a new position or takes its neighbor's.
// Depends on nps_pkg.
module nps_cell (
  input  logic          clk_i,
  input  logic          load_i,
  input  logic          shift_i,
  input  nps_pkg::pos_t load_pos_i,
  input  nps_pkg::pos_t shift_pos_i,
  output nps_pkg::pos_t pos_o
);
  import nps_pkg::*;

  pos_t pos_q, pos_d;

  always_comb begin
    pos_d = pos_q;
    if (load_i) begin
      pos_d = load_pos_i;
    end else if (shift_i) begin
      pos_d = shift_pos_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
  end

  assign pos_o = pos_q;

endmodule

@@ rtl/core/nps_dist.sv @@
// Squared distance pipeline and running minimum over the probes of one table.
// Three stages: magnitude, square, sum and compare. Depends on nps_pkg.
module nps_dist (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  nps_pkg::pos_t             probe_i,
  input  nps_pkg::pos_t             query_i,
  input  logic                      valid_i,
  input  logic [nps_pkg::IDX_W-1:0] idx_i,
  output logic [nps_pkg::IDX_W-1:0] best_idx_o
);
  import nps_pkg::*;

  localparam int unsigned DIFF_W = COORD_BITS + 1;

  function automatic logic [COORD_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                     input logic [COORD_BITS-1:0] b);
    logic signed [DIFF_W-1:0] d;
    d = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
    if (d[DIFF_W-1]) begin
      d = -d;
    end
    return d[COORD_BITS-1:0];
  endfunction

  logic                  v1_q, v1_d, v2_q, v2_d;
  logic [IDX_W-1:0]      i1_q, i1_d, i2_q, i2_d;
  logic [COORD_BITS-1:0] mx_q, mx_d, my_q, my_d, mz_q, mz_d;
  logic [SQ_W-1:0]       sx_q, sx_d, sy_q, sy_d, sz_q, sz_d;
  logic [SUM_W-1:0]      best_sum_q, best_sum_d;
  logic [IDX_W-1:0]      best_idx_q, best_idx_d;
  logic [SUM_W-1:0]      sum;
  logic                  take;

  always_comb begin
    v1_d = valid_i;
    i1_d = idx_i;
    mx_d = abs_diff(probe_i.x, query_i.x);
    my_d = abs_diff(probe_i.y, query_i.y);
    mz_d = abs_diff(probe_i.z, query_i.z);

    v2_d = v1_q;
    i2_d = i1_q;
    sx_d = mx_q * mx_q;
    sy_d = my_q * my_q;
    sz_d = mz_q * mz_q;

    sum  = SUM_W'(sx_q) + SUM_W'(sy_q) + SUM_W'(sz_q);
    // entry zero opens a new search; strict less keeps the lowest index on ties
    take = v2_q && ((i2_q == '0) || (sum < best_sum_q));
    best_sum_d = take ? sum : best_sum_q;
    best_idx_d = take ? i2_q : best_idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i1_q       <= i1_d;
    i2_q       <= i2_d;
    mx_q       <= mx_d;
    my_q       <= my_d;
    mz_q       <= mz_d;
    sx_q       <= sx_d;
    sy_q       <= sy_d;
    sz_q       <= sz_d;
    best_sum_q <= best_sum_d;
    best_idx_q <= best_idx_d;
  end

  assign best_idx_o = best_idx_q;

endmodule

@@ rtl/core/nps_table.sv @@
// One probe table: a ring of cells rotating past a shared distance pipeline.
// Depends on nps_pkg, nps_cell and nps_dist.
module nps_table (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  nps_pkg::tbl_ctl_t         ctl_i,
  input  nps_pkg::pos_t             load_pos_i,
  input  nps_pkg::pos_t             query_i,
  output logic [nps_pkg::IDX_W-1:0] best_idx_o
);
  import nps_pkg::*;

  pos_t cell_pos [MAX_PROBES];

  for (genvar g = 0; g < MAX_PROBES; g++) begin : g_cell
    localparam int unsigned NXT = (g + 1) % MAX_PROBES;
    nps_cell u_cell (
      .clk_i      (clk_i),
      .load_i     (ctl_i.load && (ctl_i.load_idx == IDX_W'(g))),
      .shift_i    (ctl_i.shift),
      .load_pos_i (load_pos_i),
      .shift_pos_i(cell_pos[NXT]),
      .pos_o      (cell_pos[g])
    );
  end

  // cell 0 is the head of the ring
  nps_dist u_dist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .probe_i   (cell_pos[0]),
    .query_i   (query_i),
    .valid_i   (ctl_i.scan_valid),
    .idx_i     (ctl_i.scan_idx),
    .best_idx_o(best_idx_o)
  );

endmodule
